[design/smm_pkg.sv]
package smm_pkg;

	// default sizes of the stores
	localparam int DEF_MAX_COLS  = 64;
	localparam int DEF_MAX_INNER = 256;
	localparam int DEF_MAX_C_NNZ = 1024;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int IDX_W   = 11;
	localparam int COL_W   = 6;
	localparam int VAL_W   = 32;
	localparam int ACC_W   = 48;
	localparam int ROW_W   = 16;
	localparam int PTR_W   = 11;
	localparam int NCOLS_W = 7;
	localparam int NINN_W  = 9;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int FRAC_W  = 16;

	// register select values (paddr[2] picks the register)
	localparam logic REG_NUM_COLS  = 1'b0;
	localparam logic REG_NUM_INNER = 1'b1;

	// command codes
	typedef enum logic [OP_W-1:0] {
		OP_PTR     = 3'd0,
		OP_CENTRY  = 3'd1,
		OP_BENTRY  = 3'd2,
		OP_ROW_END = 3'd3,
		OP_RESTART = 3'd4
	} op_t;

	// controller states
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_PTR_A  = 10'b0000000010,
		ST_PTR_B  = 10'b0000000100,
		ST_PTR_C  = 10'b0000001000,
		ST_WALK_A = 10'b0000010000,
		ST_WALK_B = 10'b0000100000,
		ST_WALK_C = 10'b0001000000,
		ST_SCAN   = 10'b0010000000,
		ST_DRAIN  = 10'b0100000000,
		ST_FIN    = 10'b1000000000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic ptr_hi;
		logic ld_start;
		logic ld_end;
		logic mul;
		logic acc_wr;
		logic scan;
		logic fin;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad_k;
		logic walk_done;
		logic scan_last;
	} dp_stat_t;

endpackage

[design/smm_ram.sv]
module smm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/smm_ctrl.sv]
module smm_ctrl
	import smm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [OP_W-1:0] opcode,
	input  dp_stat_t       stat,
	output dp_cmd_t        cmd,
	output logic           busy
);

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (opcode == OP_BENTRY && !stat.bad_k) begin
						state_d = ST_PTR_A;
					end else if (opcode == OP_ROW_END) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_PTR_A:  state_d = ST_PTR_B;
			ST_PTR_B:  state_d = ST_PTR_C;
			ST_PTR_C:  state_d = ST_WALK_A;
			ST_WALK_A: state_d = stat.walk_done ? ST_IDLE : ST_WALK_B;
			ST_WALK_B: state_d = ST_WALK_C;
			ST_WALK_C: state_d = ST_WALK_A;
			ST_SCAN:   state_d = stat.scan_last ? ST_DRAIN : ST_SCAN;
			ST_DRAIN:  state_d = ST_FIN;
			ST_FIN:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.accept   = start && (state_q == ST_IDLE);
		cmd.ptr_hi   = (state_q == ST_PTR_B);
		cmd.ld_start = (state_q == ST_PTR_B);
		cmd.ld_end   = (state_q == ST_PTR_C);
		cmd.mul      = (state_q == ST_WALK_B);
		cmd.acc_wr   = (state_q == ST_WALK_C);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.fin      = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/smm_dp.sv]
module smm_dp
	import smm_pkg::*;
#(
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_INNER = DEF_MAX_INNER,
	parameter int MAX_C_NNZ = DEF_MAX_C_NNZ
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	input  logic [OP_W-1:0]         opcode,
	input  logic [IDX_W-1:0]        index,
	input  logic [COL_W-1:0]        entry_col,
	input  logic signed [VAL_W-1:0] value,
	input  logic [NCOLS_W-1:0]      num_cols,
	input  logic [NINN_W-1:0]       num_inner,
	output logic                    out_valid,
	output logic [ROW_W-1:0]        out_row,
	output logic [COL_W-1:0]        out_col,
	output logic signed [ACC_W-1:0] out_value,
	output logic                    last_in_row,
	output logic                    empty_row,
	output logic                    index_error
);

	localparam int PDEPTH = MAX_INNER + 1;
	localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
	localparam int EAW    = (MAX_C_NNZ > 1) ? $clog2(MAX_C_NNZ) : 1;
	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int EW     = COL_W + VAL_W;

	// input capture
	logic [PAW-1:0]          k_q;
	logic signed [VAL_W-1:0] val_q;

	// walk pointers
	logic [PTR_W-1:0] q_q, end_q;

	// product stage
	logic signed [PROD_W-1:0] prod_s1;
	logic [CW-1:0]            col_s1;
	logic                     colok_s1;

	// scan stage
	logic [CW-1:0] j_q;
	logic          sv_s1;
	logic [CW-1:0] sj_s1;

	// pending result of the scan
	logic                    pend_v_q;
	logic [COL_W-1:0]        pend_col_q;
	logic signed [ACC_W-1:0] pend_val_q;

	logic [MAX_COLS-1:0] touched_q;
	logic [ROW_W-1:0]    row_q;
	logic                err_q;

	// memory ports
	logic                 ptr_we;
	logic [PAW-1:0]       ptr_raddr;
	logic [PTR_W-1:0]     ptr_rdata;
	logic                 ent_we;
	logic [EW-1:0]        ent_rdata;
	logic [COL_W-1:0]     ent_col;
	logic signed [VAL_W-1:0] ent_val;
	logic                 acc_we;
	logic [CW-1:0]        acc_raddr;
	logic signed [ACC_W-1:0] acc_rdata;
	logic signed [ACC_W-1:0] acc_wdata;

	logic signed [ACC_W-1:0] prod_q16;
	logic signed [ACC_W:0]   sum;
	logic signed [ACC_W-1:0] sum_sat;
	logic                    hit;
	logic [PTR_W-1:0]        end_clamp;

	assign ent_col = ent_rdata[EW-1:VAL_W];
	assign ent_val = ent_rdata[VAL_W-1:0];

	// decode of loads and bad index
	assign ptr_we = cmd.accept && (opcode == OP_PTR) && (32'(index) <= MAX_INNER);
	assign ent_we = cmd.accept && (opcode == OP_CENTRY) && (32'(index) < MAX_C_NNZ);
	assign stat.bad_k = (32'(index) >= 32'(num_inner)) || (32'(index) >= MAX_INNER);
	assign stat.walk_done = (q_q >= end_q);
	assign stat.scan_last = (j_q == CW'(MAX_COLS - 1));

	assign ptr_raddr = cmd.ptr_hi ? PAW'(k_q + 1'b1) : k_q;
	assign acc_raddr = cmd.scan ? j_q : CW'(ent_col);

	assign end_clamp = (32'(ptr_rdata) > MAX_C_NNZ) ? PTR_W'(MAX_C_NNZ) : ptr_rdata;

	smm_ram #(.WIDTH(PTR_W), .DEPTH(PDEPTH)) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (PAW'(index)),
		.wdata (value[PTR_W-1:0]),
		.raddr (ptr_raddr),
		.rdata (ptr_rdata)
	);

	smm_ram #(.WIDTH(EW), .DEPTH(MAX_C_NNZ)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (EAW'(index)),
		.wdata ({entry_col, value}),
		.raddr (EAW'(q_q)),
		.rdata (ent_rdata)
	);

	smm_ram #(.WIDTH(ACC_W), .DEPTH(MAX_COLS)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (col_s1),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// accumulate with saturation, first product sets the sum
	assign prod_q16 = prod_s1[PROD_W-1:FRAC_W];
	assign sum = {acc_rdata[ACC_W-1], acc_rdata} + {prod_q16[ACC_W-1], prod_q16};
	always_comb begin
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
	end
	assign acc_wdata = touched_q[col_s1] ? sum_sat : prod_q16;
	assign acc_we    = cmd.acc_wr && colok_s1;

	assign hit = sv_s1 && touched_q[sj_s1] && (acc_rdata != '0);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			k_q   <= PAW'(index);
			val_q <= value;
		end
		if (cmd.ld_start) begin
			q_q <= ptr_rdata;
		end else if (cmd.mul) begin
			q_q <= q_q + 1'b1;
		end
		if (cmd.ld_end) begin
			end_q <= end_clamp;
		end
		if (cmd.mul) begin
			prod_s1  <= val_q * ent_val;
			col_s1   <= CW'(ent_col);
			colok_s1 <= (32'(ent_col) < 32'(num_cols)) && (32'(ent_col) < MAX_COLS);
		end
		if (cmd.accept) begin
			j_q <= '0;
		end else if (cmd.scan) begin
			j_q <= j_q + 1'b1;
		end
		sj_s1 <= j_q;
		if (hit) begin
			pend_col_q <= COL_W'(sj_s1);
			pend_val_q <= acc_rdata;
		end
		// result word
		if (hit) begin
			out_row     <= row_q;
			out_col     <= pend_col_q;
			out_value   <= pend_val_q;
			last_in_row <= 1'b0;
			empty_row   <= 1'b0;
		end else if (cmd.fin) begin
			out_row     <= row_q;
			out_col     <= pend_v_q ? pend_col_q : '0;
			out_value   <= pend_v_q ? pend_val_q : '0;
			last_in_row <= 1'b1;
			empty_row   <= !pend_v_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= '0;
			row_q     <= '0;
			err_q     <= 1'b0;
			sv_s1     <= 1'b0;
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			sv_s1     <= cmd.scan;
			out_valid <= (hit && pend_v_q) || cmd.fin;
			if (cmd.accept && opcode == OP_BENTRY && stat.bad_k) begin
				err_q <= 1'b1;
			end
			if (cmd.accept && opcode == OP_RESTART) begin
				touched_q <= '0;
				row_q     <= '0;
				err_q     <= 1'b0;
			end
			if (acc_we) begin
				touched_q[col_s1] <= 1'b1;
			end
			if (cmd.accept) begin
				pend_v_q <= 1'b0;
			end else if (hit) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.fin) begin
				touched_q <= '0;
				row_q     <= row_q + 1'b1;
			end
		end
	end

	assign index_error = err_q;

endmodule

[design/sparse_row_matrix_multiply.sv]
// Sparse row product A = B*C with C held in CSR form. Load C with row-pointer
// and entry commands, then stream B rows as entries and an end-of-row command.
// Pointer and entry loads, restart and a bad inner index are done when accepted.
// A B entry fetches the two row pointers of C, then takes each C entry in that
// row through entry memory read, multiply and accumulator read-modify-write.
// An end of row scans the accumulator memory one column a cycle, then drains
// and finishes. Results come out as one-cycle out_valid words in ascending
// column order and cannot be held off; busy stays high while an item is at
// work and start is ignored meanwhile.
module sparse_row_matrix_multiply
	import smm_pkg::*;
#(
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_INNER = DEF_MAX_INNER,
	parameter int MAX_C_NNZ = DEF_MAX_C_NNZ
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic [OP_W-1:0]         opcode,
	input  logic [IDX_W-1:0]        index,
	input  logic [COL_W-1:0]        entry_col,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	output logic [ROW_W-1:0]        out_row,
	output logic [COL_W-1:0]        out_col,
	output logic signed [ACC_W-1:0] out_value,
	output logic                    last_in_row,
	output logic                    empty_row,
	output logic                    index_error
);

	logic [NCOLS_W-1:0] num_cols_q;
	logic [NINN_W-1:0]  num_inner_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q  <= NCOLS_W'(64);
			num_inner_q <= NINN_W'(256);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_NUM_COLS) begin
				num_cols_q <= pwdata[NCOLS_W-1:0];
			end else begin
				num_inner_q <= pwdata[NINN_W-1:0];
			end
		end
	end
	assign prdata = (paddr[2] == REG_NUM_INNER) ? 32'(num_inner_q) : 32'(num_cols_q);

	smm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	smm_dp #(
		.MAX_COLS  (MAX_COLS),
		.MAX_INNER (MAX_INNER),
		.MAX_C_NNZ (MAX_C_NNZ)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.index       (index),
		.entry_col   (entry_col),
		.value       (value),
		.num_cols    (num_cols_q),
		.num_inner   (num_inner_q),
		.out_valid   (out_valid),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_value   (out_value),
		.last_in_row (last_in_row),
		.empty_row   (empty_row),
		.index_error (index_error)
	);

endmodule

[test/smm_checker.sv]
`timescale 1ns / 100ps

module smm_checker
	import smm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	input  logic                    start,
	input  logic                    busy,
	input  logic [OP_W-1:0]         opcode,
	input  logic [IDX_W-1:0]        index,
	input  logic [COL_W-1:0]        entry_col,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    out_valid,
	input  logic [ROW_W-1:0]        out_row,
	input  logic [COL_W-1:0]        out_col,
	input  logic signed [ACC_W-1:0] out_value,
	input  logic                    last_in_row,
	input  logic                    empty_row,
	input  logic                    index_error,
	output int                      errors,
	output int                      pending
);

	localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	typedef struct {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [ACC_W-1:0] sum;
		logic             last;
		logic             empty;
		logic             err;
	} product_word_t;

	product_word_t expected_words[$];

	// own copy of the block state
	logic [NCOLS_W-1:0] cols_reg;
	logic [NINN_W-1:0]  inner_reg;
	logic [PTR_W-1:0]   row_start_mem [0:DEF_MAX_INNER];
	logic [COL_W-1:0]   entry_col_mem [0:DEF_MAX_C_NNZ-1];
	logic [VAL_W-1:0]   entry_val_mem [0:DEF_MAX_C_NNZ-1];
	longint             col_sum [0:DEF_MAX_COLS-1];
	bit                 col_hit [0:DEF_MAX_COLS-1];
	logic [ROW_W-1:0]   row_count;
	bit                 bad_index_seen;

	assign pending = expected_words.size();

	function automatic void clear_sums();
		for (int j = 0; j < DEF_MAX_COLS; j++) begin
			col_sum[j] = 0;
			col_hit[j] = 0;
		end
	endfunction

	function automatic void push_word(int j, longint s, bit last, bit empty);
		product_word_t w;
		w.row = row_count;
		w.col = j[COL_W-1:0];
		w.sum = s[ACC_W-1:0];
		w.last = last;
		w.empty = empty;
		w.err = bad_index_seen;
		expected_words.push_back(w);
	endfunction

	// work out what one accepted word does
	function automatic void apply_word();
		int ncols;
		int ninner;
		int q;
		int e;
		int j;
		int n;
		longint p;
		longint s;
		ncols = (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_reg;
		ninner = (inner_reg > DEF_MAX_INNER) ? DEF_MAX_INNER : inner_reg;
		case (opcode)
			OP_PTR: begin
				if (index <= DEF_MAX_INNER)
					row_start_mem[index] = value[PTR_W-1:0];
			end
			OP_CENTRY: begin
				if (index < DEF_MAX_C_NNZ) begin
					entry_col_mem[index] = entry_col;
					entry_val_mem[index] = value;
				end
			end
			OP_BENTRY: begin
				if (index >= ninner) begin
					bad_index_seen = 1;
				end else begin
					q = row_start_mem[index];
					e = row_start_mem[index + 1];
					if (e > DEF_MAX_C_NNZ)
						e = DEF_MAX_C_NNZ;
					for (; q < e; q++) begin
						j = entry_col_mem[q];
						if (j < ncols) begin
							p = (longint'(value) * longint'($signed(entry_val_mem[q]))) >>> FRAC_W;
							if (!col_hit[j]) begin
								col_hit[j] = 1;
								col_sum[j] = p;
							end else begin
								s = col_sum[j] + p;
								if (s > SUM_MAX)
									s = SUM_MAX;
								else if (s < SUM_MIN)
									s = SUM_MIN;
								col_sum[j] = s;
							end
						end
					end
				end
			end
			OP_ROW_END: begin
				n = 0;
				for (j = 0; j < DEF_MAX_COLS; j++) begin
					if (col_hit[j] && col_sum[j] != 0) begin
						push_word(j, col_sum[j], 0, 0);
						n++;
					end
				end
				if (n == 0)
					push_word(0, 0, 1, 1);
				else
					expected_words[expected_words.size() - 1].last = 1;
				clear_sums();
				row_count = row_count + 1'b1;
			end
			OP_RESTART: begin
				clear_sums();
				row_count = '0;
				bad_index_seen = 0;
			end
			default: ;
		endcase
	endfunction

	// compare one result word with the oldest expectation
	function automatic void check_word();
		product_word_t w;
		if (expected_words.size() == 0) begin
			$error("unexpected result word: row %0d col %0d value %0d",
				out_row, out_col, out_value);
			errors++;
			return;
		end
		w = expected_words.pop_front();
		if (out_row !== w.row) begin
			$error("out_row: expected %0d, actual %0d", w.row, out_row);
			errors++;
		end
		if (out_col !== w.col) begin
			$error("out_col: expected %0d, actual %0d", w.col, out_col);
			errors++;
		end
		if (out_value !== w.sum) begin
			$error("out_value: expected %0d, actual %0d", $signed(w.sum), out_value);
			errors++;
		end
		if (last_in_row !== w.last) begin
			$error("last_in_row: expected %0d, actual %0d", w.last, last_in_row);
			errors++;
		end
		if (empty_row !== w.empty) begin
			$error("empty_row: expected %0d, actual %0d", w.empty, empty_row);
			errors++;
		end
		if (index_error !== w.err) begin
			$error("index_error: expected %0d, actual %0d", w.err, index_error);
			errors++;
		end
	endfunction

	// watch the channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			cols_reg = DEF_MAX_COLS;
			inner_reg = DEF_MAX_INNER;
			clear_sums();
			row_count = '0;
			bad_index_seen = 0;
		end else begin
			if (out_valid)
				check_word();
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_NUM_COLS)
					cols_reg = pwdata[NCOLS_W-1:0];
				else
					inner_reg = pwdata[NINN_W-1:0];
			end
			if (start && !busy)
				apply_word();
		end
	end

endmodule

[test/tb_sparse_row_matrix_multiply.sv]
`timescale 1ns / 100ps

module tb_sparse_row_matrix_multiply
	import smm_pkg::*;
();

	localparam int STALL_LIMIT = 20000;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    psel = 0;
	logic                    penable = 0;
	logic                    pwrite = 0;
	logic [2:0]              paddr = '0;
	logic [31:0]             pwdata = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    start = 0;
	logic                    busy;
	logic [OP_W-1:0]         opcode = '0;
	logic [IDX_W-1:0]        index = '0;
	logic [COL_W-1:0]        entry_col = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic [ROW_W-1:0]        out_row;
	logic [COL_W-1:0]        out_col;
	logic signed [ACC_W-1:0] out_value;
	logic                    last_in_row;
	logic                    empty_row;
	logic                    index_error;
	int                      errors;
	int                      pending;

	// what the stimulus knows of the loaded C, so no unwritten slot is read
	int ptr_copy [0:DEF_MAX_INNER];
	bit ptr_written [0:DEF_MAX_INNER];
	bit entry_written [0:DEF_MAX_C_NNZ-1];
	int inner_now;
	int idle_pct;
	int stall_count = 0;

	sparse_row_matrix_multiply uut (.*);

	smm_checker u_checker (.*);

	always #1 clk = ~clk;

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((start && !busy) || out_valid || (psel && penable))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("** sparse_row_matrix_multiply: FAILED **");
			$finish;
		end
	end

	task automatic issue(input op_t op, input int idx, input int col, input logic [31:0] val);
		opcode <= op;
		index <= idx[IDX_W-1:0];
		entry_col <= col[COL_W-1:0];
		value <= val;
		start <= 1;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic put_ptr(input int slot, input logic [31:0] val);
		if (slot <= DEF_MAX_INNER) begin
			ptr_copy[slot] = val[PTR_W-1:0];
			ptr_written[slot] = 1;
		end
		issue(OP_PTR, slot, $urandom_range(63), val);
	endtask

	task automatic put_entry(input int pos, input int col, input logic [31:0] val);
		if (pos < DEF_MAX_C_NNZ)
			entry_written[pos] = 1;
		issue(OP_CENTRY, pos, col, val);
	endtask

	function automatic bit row_safe(int k);
		int e;
		if (!ptr_written[k] || !ptr_written[k + 1])
			return 0;
		e = (ptr_copy[k + 1] > DEF_MAX_C_NNZ) ? DEF_MAX_C_NNZ : ptr_copy[k + 1];
		for (int q = ptr_copy[k]; q < e; q++)
			if (!entry_written[q])
				return 0;
		return 1;
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = 32'($urandom_range(0, 3) << 16) + 32'($urandom_range(0, 65535));
			2: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: v = -(32'($urandom_range(0, 3) << 16) + 32'($urandom_range(0, 65535)));
		endcase
		return v;
	endfunction

	// wait until every expected word is out and the block has settled
	task automatic drain();
		if (start)
			start <= 0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (DEF_MAX_COLS + 8) @(posedge clk);
	endtask

	task automatic reg_write(input logic addr_bit, input logic [31:0] data);
		psel <= 1;
		pwrite <= 1;
		paddr <= {addr_bit, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	// load a small C over the first rows, then stream random B rows
	task automatic random_phase(input int ncols, input int ninner, input int pct, input int rows);
		int nr;
		int cur;
		int nxt;
		int nb;
		int k;
		drain();
		reg_write(REG_NUM_COLS, 32'({$urandom, 7'b0}) | 32'(ncols));
		reg_write(REG_NUM_INNER, 32'({$urandom, 9'b0}) | 32'(ninner));
		inner_now = (ninner > DEF_MAX_INNER) ? DEF_MAX_INNER : ninner;
		idle_pct = pct;
		nr = (inner_now > 10) ? 10 : inner_now;
		cur = $urandom_range(0, 1000);
		if (nr > 0)
			put_ptr(0, 32'({$urandom, 11'b0}) | 32'(cur));
		for (int i = 0; i < nr; i++) begin
			if ($urandom_range(9) == 0)
				nxt = cur - $urandom_range(0, 3);
			else
				nxt = cur + $urandom_range(0, 5);
			if (nxt < 0)
				nxt = 0;
			for (int q = cur; q < nxt; q++)
				put_entry(q, $urandom_range(63), rand_value());
			put_ptr(i + 1, 32'({$urandom, 11'b0}) | 32'(nxt));
			cur = nxt;
		end
		for (int r = 0; r < rows; r++) begin
			nb = $urandom_range(0, 6);
			for (int b = 0; b < nb; b++) begin
				if (nr == 0 || $urandom_range(99) < 8)
					k = $urandom_range(0, 2047);
				else
					k = $urandom_range(0, nr - 1);
				if (k < inner_now && !row_safe(k))
					k = 2047;
				issue(OP_BENTRY, k, $urandom_range(63), rand_value());
			end
			if ($urandom_range(99) < 4)
				issue(op_t'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
			if ($urandom_range(99) < 5)
				issue(OP_RESTART, $urandom, $urandom, $urandom);
			issue(OP_ROW_END, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		idle_pct = 0;
		for (int i = 0; i < DEF_MAX_C_NNZ; i++)
			entry_written[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// low row pointers and the top slot to zero, junk in the unused upper bits
		for (int i = 0; i < 16; i++)
			put_ptr(i, 32'({$urandom, 11'b0}));
		put_ptr(DEF_MAX_INNER, 32'({$urandom, 11'b0}));

		// directed: two huge products into one column saturate upwards
		put_ptr(1, 3);
		put_ptr(2, 5);
		put_ptr(3, 1);
		put_entry(0, 5, 32'h8000_0000);
		put_entry(1, 5, 32'h8000_0000);
		put_entry(2, 63, 32'h7FFF_FFFF);
		put_entry(3, 0, 32'h7FFF_FFFF);
		put_entry(4, 5, 32'h8000_0000);
		// row walk clamped at the end of entry storage
		put_ptr(200, 1022);
		put_ptr(201, 32'hFFFF_FFFF);
		put_entry(1022, 7, 32'h0001_8000);
		put_entry(1023, 7, 32'hFFFE_0000);
		// ignored slots and positions
		issue(OP_PTR, 257, 0, 5);
		issue(OP_PTR, 2047, 0, 5);
		issue(OP_CENTRY, 1024, 3, 32'h1234_5678);
		issue(OP_CENTRY, 2047, 63, 32'hFFFF_FFFF);

		issue(OP_BENTRY, 0, 0, 32'h8000_0000);
		issue(OP_BENTRY, 0, 0, 32'h8000_0000);
		issue(OP_ROW_END, 0, 0, 0);
		// products of both signs accumulated over repeated entries
		issue(OP_BENTRY, 1, 0, 32'h8000_0000);
		issue(OP_BENTRY, 1, 0, 32'h7FFF_FFFF);
		issue(OP_BENTRY, 1, 0, 32'h7FFF_FFFF);
		issue(OP_ROW_END, 0, 0, 0);
		issue(OP_BENTRY, 200, 0, 32'h0002_0000);
		issue(OP_BENTRY, 2, 0, 32'h0001_0000);
		issue(OP_ROW_END, 0, 0, 0);
		// empty row, then a zero sum row
		issue(OP_ROW_END, 0, 0, 0);
		issue(OP_BENTRY, 0, 0, 0);
		issue(OP_ROW_END, 0, 0, 0);
		// bad inner index, unused codes, restart
		issue(OP_BENTRY, 300, 0, 32'h0001_0000);
		issue(OP_BENTRY, 2047, 63, 32'hFFFF_FFFF);
		issue(op_t'(5), 0, 0, 0);
		issue(op_t'(6), 2047, 63, 32'hFFFF_FFFF);
		issue(op_t'(7), 0, 0, 0);
		issue(OP_ROW_END, 0, 0, 0);
		issue(OP_RESTART, 0, 0, 0);
		issue(OP_ROW_END, 0, 0, 0);

		// random phases over several register settings
		random_phase(1, 1, 58, 8);
		random_phase(127, 511, 0, 8);
		random_phase(0, 0, 8, 4);
		random_phase(33, 20, 58, 8);
		random_phase(64, 256, 8, 8);
		random_phase(7, 16, 0, 6);

		drain();
		if (errors == 0 && pending == 0) begin
			$display("** sparse_row_matrix_multiply: PASSED **");
		end else begin
			$display("** sparse_row_matrix_multiply: FAILED **");
		end
		$finish;
	end

endmodule
